// ===== rtl/multi_channel_watchdog_supervisor_macros.svh =====
// Assertion helpers used by the verification module of this block.
`ifndef MULTI_CHANNEL_WATCHDOG_SUPERVISOR_MACROS_SVH
`define MULTI_CHANNEL_WATCHDOG_SUPERVISOR_MACROS_SVH

// Property sampled on the rising clock edge, quiet while reset is held.
`define MCWS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on the rising clock edge, also checked during reset.
`define MCWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mcws_pkg.sv =====
`default_nettype none
package mcws_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

  localparam int CMD_W = 2;
  localparam int ID_W = 8;
  localparam int TIME_W = 32;
  localparam int MASK_W = 8;

  localparam logic [CMD_W-1:0] CMD_ARM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FEED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SUP_DISABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_HARD = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   wdg_id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [MASK_W-1:0] triggered_mask;
    logic              hw_feed;
  } result_t;

  typedef struct packed {
    logic                we;
    logic                set_period;
    logic [CH_IDX_W-1:0] idx;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   stamp;
  } tab_wr_t;

endpackage
`default_nettype wire

// ===== rtl/mcws_cmp.sv =====
`default_nettype none
module mcws_cmp (
  input  logic [mcws_pkg::TIME_W-1:0] now_ms,
  input  logic [mcws_pkg::TIME_W-1:0] fed_at,
  input  logic [mcws_pkg::TIME_W-1:0] period,
  output logic                        expired
);
  import mcws_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // Elapsed time wraps with the millisecond counter.
  assign elapsed = now_ms - fed_at;
  assign expired = (period != '0) && (elapsed > period);

endmodule
`default_nettype wire

// ===== rtl/mcws_chan_tab.sv =====
`default_nettype none
module mcws_chan_tab (
  input  logic                          clk,
  input  logic                          rst,
  input  mcws_pkg::tab_wr_t             wr,
  input  logic [mcws_pkg::CH_IDX_W-1:0] rd_idx,
  output logic [mcws_pkg::TIME_W-1:0]   rd_period,
  output logic [mcws_pkg::TIME_W-1:0]   rd_last
);
  import mcws_pkg::*;

  logic [TIME_W-1:0] period_regs [NUM_CHANNELS];
  logic [TIME_W-1:0] last_regs [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        period_regs[i] <= '0;
        last_regs[i] <= '0;
      end
    end else if (wr.we) begin
      last_regs[wr.idx] <= wr.stamp;
      if (wr.set_period) begin
        period_regs[wr.idx] <= wr.period;
      end
    end
  end

  assign rd_period = period_regs[rd_idx];
  assign rd_last = last_regs[rd_idx];

endmodule
`default_nettype wire

// ===== rtl/multi_channel_watchdog_supervisor.sv =====
// Multi-channel watchdog supervisor.
// A command beat is taken on a rising edge with start high and busy low; cmd
// carries the command code, channel id, period and the current millisecond time.
// Register and feed stamp a channel; register also sets its period. A check
// sweeps the channels one per clock through a single wrap-around subtract and
// compare unit, so its length is set by the channel count.
// Every command gives exactly one result beat: done is high for one cycle with
// result valid. done rises as the block leaves the EXEC state entered on accept
// for register, feed, unused codes and checks with supervision disabled, and
// for a check sweep as it leaves the SWEEP state after the last channel. busy
// drops as done rises, so the next command can be accepted on the edge that
// takes the result.
// The receiver cannot stall; it must take the result in its single cycle.
// The configuration port writes supervision_disabled (index 0) and fail_hard_mode
// (index 1) on any edge with cfg_we high; write only while idle (not enforced).
// Synchronous reset clears both registers, all channel periods and stamps, and
// returns the block to idle with no result pending.
`default_nettype none
module multi_channel_watchdog_supervisor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  mcws_pkg::cmd_t                  cmd,
  output logic                            done,
  output mcws_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [mcws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mcws_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0]          state;
  cmd_t                item;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [MASK_W-1:0]   mask;
  logic [MASK_W-1:0]   mask_next;
  logic                any_exp;
  logic                any_exp_next;
  logic                sup_disabled;
  logic                fail_hard;
  logic                id_ok;
  logic                is_chan_cmd;
  logic                expired;
  tab_wr_t             tab_wr;
  logic [TIME_W-1:0]   rd_period;
  logic [TIME_W-1:0]   rd_last;

  assign busy = (state != ST_IDLE);
  assign id_ok = (item.wdg_id < ID_W'(NUM_CHANNELS));
  assign is_chan_cmd = (item.command == CMD_ARM) || (item.command == CMD_FEED);

  always_comb begin
    tab_wr.we = (state == ST_EXEC) && is_chan_cmd && id_ok;
    tab_wr.set_period = (item.command == CMD_ARM);
    tab_wr.idx = item.wdg_id[CH_IDX_W-1:0];
    tab_wr.period = item.period;
    tab_wr.stamp = item.now_ms;
  end

  mcws_chan_tab u_chan_tab (
    .clk       (clk),
    .rst       (rst),
    .wr        (tab_wr),
    .rd_idx    (ch_idx),
    .rd_period (rd_period),
    .rd_last   (rd_last)
  );

  mcws_cmp u_cmp (
    .now_ms    (item.now_ms),
    .fed_at    (rd_last),
    .period    (rd_period),
    .expired   (expired)
  );

  always_comb begin
    any_exp_next = any_exp | expired;
    for (int b = 0; b < MASK_W; b++) begin
      mask_next[b] = mask[b] | (expired && (8'(ch_idx) == 8'(b)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      sup_disabled <= 1'b0;
      fail_hard <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_SUP_DISABLED: sup_disabled <= cfg_data[0];
          REG_FAIL_HARD: fail_hard <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if ((item.command == CMD_CHECK) && !sup_disabled) begin
            state <= ST_SWEEP;
          end else begin
            state <= ST_IDLE;
            done <= 1'b1;
          end
        end
        ST_SWEEP: begin
          if (ch_idx == LAST_CH) begin
            state <= ST_IDLE;
            done <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          item <= cmd;
        end
      end
      ST_EXEC: begin
        ch_idx <= '0;
        mask <= '0;
        any_exp <= 1'b0;
        result.status <= is_chan_cmd && !id_ok;
        result.triggered_mask <= '0;
        result.hw_feed <= (item.command == CMD_CHECK);
      end
      ST_SWEEP: begin
        ch_idx <= ch_idx + CH_IDX_W'(1);
        mask <= mask_next;
        any_exp <= any_exp_next;
        if (ch_idx == LAST_CH) begin
          result.status <= 1'b0;
          result.triggered_mask <= mask_next;
          result.hw_feed <= !any_exp_next && !fail_hard;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mcws_checker.sv =====
`default_nettype none
`include "multi_channel_watchdog_supervisor_macros.svh"
module mcws_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire mcws_pkg::result_t result
);
  import mcws_pkg::*;

  // An accepted command keeps the block busy on the following cycle.
  `MCWS_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "busy low after accept")

  // Each command gives a single result beat, never two in a row.
  `MCWS_ASSERT(a_done_single, clk, rst, done |=> !done, "result beat repeated")

  // A bad channel status comes with no mask and no hardware reload.
  `MCWS_ASSERT(a_status_clean, clk, rst,
    (done && result.status) |-> ((result.triggered_mask == '0) && !result.hw_feed),
    "bad status with check fields set")

  // An expired channel never lets the hardware watchdog be reloaded.
  `MCWS_ASSERT(a_expired_nofeed, clk, rst,
    (done && (result.triggered_mask != '0)) |-> !result.hw_feed,
    "hardware reload with expired channels")

endmodule

bind multi_channel_watchdog_supervisor mcws_checker u_checker (.*);
`default_nettype wire
